@@ design/bhks_pkg.sv @@
// Package for the bucketed hash key set: sizes, command and status codes,
// sequencer state type. Used by every other file of the block but bhks_ram.
package bhks_pkg;

   localparam int MAX_BUCKETS      = 8;
   localparam int SLOTS_PER_BUCKET = 4;
   localparam int KEY_W            = 31;
   localparam int TOTAL_SLOTS      = MAX_BUCKETS * SLOTS_PER_BUCKET;

   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_W       = 4;
   localparam int BUCKET_W    = $clog2(MAX_BUCKETS);
   localparam int DIVISOR_W   = $clog2(MAX_BUCKETS + 1);
   localparam int SLOT_IDX_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int SLOT_ADDR_W = $clog2(TOTAL_SLOTS);
   localparam int SCAN_CNT_W  = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int STEP_W      = $clog2(KEY_W);

   localparam logic [CSR_W-1:0] BUCKET_COUNT_RESET = CSR_W'(7);

   localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_SEARCH = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_DELETE = CMD_W'(2);

   localparam logic [STATUS_W-1:0] STATUS_DONE   = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_FULL   = STATUS_W'(2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_EXEC
   } state_type;

endpackage

@@ design/bhks_req_if.sv @@
// Request channel of the bucketed hash key set: valid/ready plus command and key.
// Depends on bhks_pkg.
interface bhks_req_if;
   import bhks_pkg::*;

   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [KEY_W-1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink   (input valid, input cmd, input key, output ready);
endinterface

@@ design/bhks_rsp_if.sv @@
// Response channel of the bucketed hash key set: valid/ready plus bucket, found, status.
// Depends on bhks_pkg.
interface bhks_rsp_if;
   import bhks_pkg::*;

   logic                valid;
   logic                ready;
   logic [BUCKET_W-1:0] bucket;
   logic                found;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output bucket, output found, output status, input ready);
   modport sink   (input valid, input bucket, input found, input status, output ready);
endinterface

@@ design/bhks_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bucketed_hash_key_set_core.sv @@
// Bucketed hash key set: insert / search / delete of keys in fixed-size buckets.
// Sequence per item: 31 restoring modulo steps, a slot scan on the key RAM read port,
// then the update that loads the response.
// One item at a time: ready is low after an accept through the update cycle,
// which waits while an earlier response is still stalled.
// Reset (synchronous): slot valid bits cleared, bucket_count = 7,
// no response pending. Key RAM contents are not cleared.
module bucketed_hash_key_set_core (
   input  logic                       clock,
   input  logic                       reset,
   bhks_req_if.sink                   req_ch,
   bhks_rsp_if.source                 rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [bhks_pkg::CSR_W-1:0] csr_wr_data
);
   import bhks_pkg::*;

   state_type             state_ff, state_in;
   logic [CSR_W-1:0]      bucket_count_ff;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [BUCKET_W-1:0]   rem_ff, rem_in;
   logic [SCAN_CNT_W-1:0] scan_ff, scan_in;
   logic                  match_hit_ff, match_hit_in;
   logic [SLOT_IDX_W-1:0] match_idx_ff, match_idx_in;
   logic                  free_hit_ff, free_hit_in;
   logic [SLOT_IDX_W-1:0] free_idx_ff, free_idx_in;
   logic                  slot_valid_ff [TOTAL_SLOTS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_W-1:0]   rsp_bucket_ff, rsp_bucket_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [DIVISOR_W-1:0]  divisor;
   logic [BUCKET_W:0]     shifted;
   logic [SLOT_IDX_W-1:0] cmp_idx;
   logic [SLOT_ADDR_W-1:0] cmp_addr;
   logic [SLOT_ADDR_W-1:0] rd_addr;
   logic [KEY_W-1:0]      rd_data;
   logic                  ram_wr_en;
   logic [SLOT_ADDR_W-1:0] upd_addr;
   logic                  valid_set, valid_clr;

   // Effective bucket count: zero acts as one, saturate at the bucket limit.
   always_comb begin
      if (bucket_count_ff == '0) begin
         divisor = DIVISOR_W'(1);
      end else if (bucket_count_ff > CSR_W'(MAX_BUCKETS)) begin
         divisor = DIVISOR_W'(MAX_BUCKETS);
      end else begin
         divisor = DIVISOR_W'(bucket_count_ff);
      end
   end

   // Scan compares the slot whose read was issued in the cycle before.
   assign cmp_idx  = SLOT_IDX_W'(scan_ff - SCAN_CNT_W'(1));
   assign cmp_addr = {rem_ff, cmp_idx};
   assign rd_addr  = {rem_ff, scan_ff[SLOT_IDX_W-1:0]};

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      scan_in       = scan_ff;
      match_hit_in  = match_hit_ff;
      match_idx_in  = match_idx_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      valid_set     = 1'b0;
      valid_clr     = 1'b0;
      upd_addr      = {rem_ff, free_idx_ff};
      shifted       = {rem_ff, key_ff[step_ff]};
      req_ch.ready  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               cmd_in   = req_ch.cmd;
               key_in   = req_ch.key;
               step_in  = STEP_W'(KEY_W - 1);
               rem_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one restoring step per cycle, key MSB first
            if (shifted >= (BUCKET_W + 1)'(divisor)) begin
               rem_in = BUCKET_W'(shifted - (BUCKET_W + 1)'(divisor));
            end else begin
               rem_in = BUCKET_W'(shifted);
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               scan_in      = '0;
               match_hit_in = 1'b0;
               free_hit_in  = 1'b0;
               match_idx_in = '0;
               free_idx_in  = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff != '0) begin
               if (slot_valid_ff[cmp_addr]) begin
                  if (!match_hit_ff && rd_data == key_ff) begin
                     match_hit_in = 1'b1;
                     match_idx_in = cmp_idx;
                  end
               end else if (!free_hit_ff) begin
                  free_hit_in = 1'b1;
                  free_idx_in = cmp_idx;
               end
            end
            scan_in = scan_ff + SCAN_CNT_W'(1);
            if (scan_ff == SCAN_CNT_W'(SLOTS_PER_BUCKET)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // update and response load together, once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = rem_ff;
               rsp_found_in  = match_hit_ff;
               rsp_status_in = STATUS_DONE;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (free_hit_ff) begin
                        ram_wr_en = 1'b1;
                        valid_set = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  CMD_DELETE: begin
                     upd_addr = {rem_ff, match_idx_ff};
                     if (match_hit_ff) begin
                        valid_clr = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_ABSENT;
                     end
                  end
                  default: begin
                     // search, and the unused code acting as search
                     if (!match_hit_ff) begin
                        rsp_status_in = STATUS_ABSENT;
                     end
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bucket_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else if (valid_set) begin
         slot_valid_ff[upd_addr] <= 1'b1;
      end else if (valid_clr) begin
         slot_valid_ff[upd_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      step_ff       <= step_in;
      rem_ff        <= rem_in;
      scan_ff       <= scan_in;
      match_hit_ff  <= match_hit_in;
      match_idx_ff  <= match_idx_in;
      free_hit_ff   <= free_hit_in;
      free_idx_ff   <= free_idx_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   bhks_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TOTAL_SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (upd_addr),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.bucket = rsp_bucket_ff;
   assign rsp_ch.found  = rsp_found_ff;
   assign rsp_ch.status = rsp_status_ff;

endmodule

@@ design/bhks_checker.sv @@
// Port-level checks for bucketed_hash_key_set_core, attached by bind.
// Depends on bhks_pkg; the bind connects it to the core's channel interfaces.
module bhks_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bhks_pkg::BUCKET_W-1:0] rsp_bucket,
   input logic                          rsp_found,
   input logic [bhks_pkg::STATUS_W-1:0] rsp_status
);
   import bhks_pkg::*;

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bucket) &&
                                  $stable(rsp_found) && $stable(rsp_status))
      else $error("response changed while stalled");

   // one item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready high right after accept");

   // a present key is never reported absent
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status != STATUS_ABSENT)
      else $error("found key reported absent");

   // the modulo runs between accept and response, so no response rises just after accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 !$rose(rsp_valid))
      else $error("response too soon after accept");

endmodule

bind bucketed_hash_key_set_core bhks_checker u_bhks_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_bucket (rsp_ch.bucket),
   .rsp_found  (rsp_ch.found),
   .rsp_status (rsp_ch.status)
);
